>>> rtl/ptw_pkg.sv
// Shared widths, codes, types and helpers of the page table walk unit.
package ptw_pkg;

    localparam int ADDR_W  = 52;
    localparam int WORD_W  = 64;
    localparam int VA_W    = 48;
    localparam int IDX_W   = 9;
    localparam int OFF_W   = 12;
    localparam int LVL_W   = 2;
    localparam int PAIR_W  = ADDR_W + WORD_W;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_XLATE = 1'b1;

    // Register index, taken from paddr[3] of the configuration port.
    localparam logic REG_ROOT_BASE = 1'b0;

    localparam logic [LVL_W-1:0] LAST_LEVEL = 2'd3;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [VA_W-1:0]   t_va;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [LVL_W-1:0]  t_level;

    // Commands from the walk controller to the datapath.
    typedef struct packed {
        logic   load_pair;
        logic   latch_va;
        logic   start_level;
        logic   read_k;
        logic   next_k;
        logic   take_hit;
        logic   take_miss;
        logic   set_base;
        logic   load_out;
        t_level level;
    } t_dp_cmd;

    // Status from the datapath back to the walk controller.
    typedef struct packed {
        logic k_in_range;
        logic hit;
        logic entry_ok;
        logic out_free;
    } t_dp_sts;

    // Nine index bits of the virtual address for a given table level.
    function automatic t_idx va_index(t_va va, t_level lvl);
        t_idx idx;
        case (lvl)
            2'd0:    idx = va[47:39];
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

>>> rtl/ptw_in_if.sv
// Request channel of the page table walk unit.
interface ptw_in_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [ptw_pkg::ADDR_W-1:0]  entry_address;
    logic [ptw_pkg::WORD_W-1:0]  entry_word;
    logic [ptw_pkg::VA_W-1:0]    virtual_address;

    modport source (output valid, func, entry_address, entry_word, virtual_address,
                    input ready);
    modport sink   (input valid, func, entry_address, entry_word, virtual_address,
                    output ready);
endinterface

>>> rtl/ptw_out_if.sv
// Response channel of the page table walk unit.
interface ptw_out_if;
    logic                        valid;
    logic                        ready;
    logic                        fault;
    logic [ptw_pkg::ADDR_W-1:0]  physical_address;

    modport source (output valid, fault, physical_address, input ready);
    modport sink   (input valid, fault, physical_address, output ready);
endinterface

>>> rtl/ptw_ram.sv
// Generic single write port, single read port RAM with registered read data.
module ptw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ptw_dp.sv
// Datapath of the page table walk: pair store, scan counter, walk registers, result.
module ptw_dp #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ptw_pkg::t_dp_cmd         i_cmd,
    output ptw_pkg::t_dp_sts         o_sts,
    input  logic                     i_cfg_we,
    input  ptw_pkg::t_addr           i_cfg_wdata,
    output ptw_pkg::t_addr           o_root,
    input  ptw_pkg::t_addr           i_entry_address,
    input  ptw_pkg::t_word           i_entry_word,
    input  ptw_pkg::t_va             i_virtual_address,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_fault,
    output ptw_pkg::t_addr           o_physical_address
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int FRAME_W = ptw_pkg::ADDR_W - ptw_pkg::OFF_W;

    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_k;
    ptw_pkg::t_addr              r_root;
    ptw_pkg::t_va                r_va;
    ptw_pkg::t_addr              r_base;
    ptw_pkg::t_addr              r_eaddr;
    logic                        r_entry_ok;
    logic [FRAME_W-1:0]          r_frame;
    logic                        r_out_valid;
    logic                        r_fault;
    ptw_pkg::t_addr              r_pa;

    logic                        w_full;
    logic                        w_we;
    logic [ptw_pkg::PAIR_W-1:0]  w_rdata;
    ptw_pkg::t_addr              w_rd_addr;
    ptw_pkg::t_word              w_rd_word;
    ptw_pkg::t_idx               w_idx;

    assign w_full = (r_count == CW'(TABLE_ENTRIES));
    assign w_we   = i_cmd.load_pair && !w_full;

    ptw_ram #(
        .WIDTH (ptw_pkg::PAIR_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_entry_address, i_entry_word}),
        .i_re    (i_cmd.read_k),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_rd_addr = w_rdata[ptw_pkg::PAIR_W-1:ptw_pkg::WORD_W];
    assign w_rd_word = w_rdata[ptw_pkg::WORD_W-1:0];
    assign w_idx     = ptw_pkg::va_index(r_va, i_cmd.level);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_root      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_we) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cfg_we) begin
                r_root <= i_cfg_wdata;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_va) begin
            r_va   <= i_virtual_address;
            r_base <= r_root;
        end
        if (i_cmd.start_level) begin
            // Entry address wraps within the physical address width.
            r_eaddr <= r_base + {{(ptw_pkg::ADDR_W - ptw_pkg::IDX_W - 3){1'b0}}, w_idx, 3'b000};
            r_k     <= '0;
        end
        if (i_cmd.next_k) begin
            r_k <= r_k + CW'(1);
        end
        if (i_cmd.take_hit) begin
            r_entry_ok <= w_rd_word[0];
            r_frame    <= w_rd_word[ptw_pkg::ADDR_W-1:ptw_pkg::OFF_W];
        end
        if (i_cmd.take_miss) begin
            r_entry_ok <= 1'b0;
        end
        if (i_cmd.set_base) begin
            r_base <= {r_frame, {ptw_pkg::OFF_W{1'b0}}};
        end
        if (i_cmd.load_out) begin
            r_fault <= !r_entry_ok;
            // The base has clear low bits, so adding the offset is a concatenation.
            r_pa    <= r_entry_ok ? {r_base[ptw_pkg::ADDR_W-1:ptw_pkg::OFF_W],
                                     r_va[ptw_pkg::OFF_W-1:0]} : '0;
        end
    end

    assign o_sts.k_in_range = (r_k < r_count);
    assign o_sts.hit        = (w_rd_addr == r_eaddr);
    assign o_sts.entry_ok   = r_entry_ok;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_root             = r_root;
    assign o_out_valid        = r_out_valid;
    assign o_fault            = r_fault;
    assign o_physical_address = r_pa;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES))
        else $error("pair count exceeds store depth");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_out_valid)
        else $error("result register not valid after load");

endmodule

>>> rtl/ptw_ctrl.sv
// Walk controller: sequences loads, the four table levels and result delivery.
module ptw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_func,
    output logic              o_in_ready,
    input  ptw_pkg::t_dp_sts  i_sts,
    output ptw_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADDR  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]       r_state, n_state;
    ptw_pkg::t_level  r_level, n_level;
    logic             w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_level = r_level;
        o_cmd   = '0;
        o_cmd.level = r_level;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_func == ptw_pkg::FUNC_LOAD) begin
                        o_cmd.load_pair = 1'b1;
                    end else begin
                        o_cmd.latch_va = 1'b1;
                        n_level = '0;
                        n_state = S_ADDR;
                    end
                end
            end
            S_ADDR: begin
                o_cmd.start_level = 1'b1;
                n_state = S_RD;
            end
            S_RD: begin
                if (i_sts.k_in_range) begin
                    o_cmd.read_k = 1'b1;
                    n_state = S_CMP;
                end else begin
                    // No stored pair matched: the entry reads as zero.
                    o_cmd.take_miss = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CMP: begin
                if (i_sts.hit) begin
                    o_cmd.take_hit = 1'b1;
                    n_state = S_CHECK;
                end else begin
                    o_cmd.next_k = 1'b1;
                    n_state = S_RD;
                end
            end
            S_CHECK: begin
                if (!i_sts.entry_ok) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.set_base = 1'b1;
                    if (r_level == ptw_pkg::LAST_LEVEL) begin
                        n_state = S_DONE;
                    end else begin
                        n_level = r_level + 2'd1;
                        n_state = S_ADDR;
                    end
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_level <= '0;
        end else begin
            r_state <= n_state;
            r_level <= n_level;
        end
    end

    a_cmp_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ($past(r_state) == S_RD))
        else $error("compare state entered without a store read");

    a_fault_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) && !i_sts.entry_ok |=> (r_state == S_DONE))
        else $error("walk continued past a non-present entry");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && !i_sts.out_free |=> (r_state == S_DONE))
        else $error("result dropped while the output register was full");

endmodule

>>> rtl/four_level_page_table_walk_unit.sv
// Top level of the four-level page table walk unit.
//
// Requests arrive on i_req (valid/ready). A load transaction (func 0) appends
// one address/word pair to the internal store in the cycle it is accepted and
// gives no response; loads past TABLE_ENTRIES pairs are dropped. A translate
// transaction (func 1) walks up to four table levels from root_table_base
// and gives one response on o_rsp with the fault flag and physical address.
// Each level forms the entry address, then scans the store in load order
// through its single read port, one pair at a time, until the first match or
// the end of the stored pairs.
// One request is worked on at a time; a new request is taken once the walk has
// moved its result into the output register, so a response may wait on a
// stalled receiver while the next request is accepted. If the output register
// is still full when a walk ends, the unit holds the result and stops taking
// requests until o_rsp.ready frees it.
// Reset clears the pair count, the root base and the output valid; the store
// needs no clearing pass. root_table_base sits at APB address 0 (64-bit data).
module four_level_page_table_walk_unit #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ptw_in_if.sink             i_req,
    ptw_out_if.source          o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    ptw_pkg::t_dp_cmd  w_cmd;
    ptw_pkg::t_dp_sts  w_sts;
    ptw_pkg::t_addr    w_root;
    logic              w_cfg_we;
    logic              w_in_ready;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && (paddr[3] == ptw_pkg::REG_ROOT_BASE);
    assign prdata   = (paddr[3] == ptw_pkg::REG_ROOT_BASE) ?
                      {{(64 - ptw_pkg::ADDR_W){1'b0}}, w_root} : '0;

    assign i_req.ready = w_in_ready;

    ptw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_func  (i_req.func),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ptw_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_cfg_we           (w_cfg_we),
        .i_cfg_wdata        (pwdata[ptw_pkg::ADDR_W-1:0]),
        .o_root             (w_root),
        .i_entry_address    (i_req.entry_address),
        .i_entry_word       (i_req.entry_word),
        .i_virtual_address  (i_req.virtual_address),
        .o_out_valid        (o_rsp.valid),
        .i_out_ready        (o_rsp.ready),
        .o_fault            (o_rsp.fault),
        .o_physical_address (o_rsp.physical_address)
    );

endmodule
